// File: design/hid_keyboard_report_to_set1_defines.svh
// Assertion macros used by the checker file of the keyboard scancode block.
`ifndef HID_KEYBOARD_REPORT_TO_SET1_DEFINES_SVH
`define HID_KEYBOARD_REPORT_TO_SET1_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define HKB_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define HKB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Check of the state that reset leaves behind.
`define HKB_ASSERT_RST(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

// File: design/hkb_pkg.sv
// Package of types, constants and a lookup function for the keyboard scancode block.
`default_nettype none

package hkb_pkg;

  localparam int REPORT_SLOTS     = 6;
  localparam int USAGE_TABLE_SIZE = 102;
  localparam int IDX_W            = 3;
  localparam int OUTQ_DEPTH       = 4;
  localparam int OUTQ_PTR_W       = 2;

  localparam logic [7:0]  EXT_PREFIX   = 8'hE0;
  localparam logic [15:0] TICK_MAX     = 16'hFFFF;
  localparam logic [15:0] DELAY_RESET  = 16'd500;
  localparam logic [15:0] PERIOD_RESET = 16'd33;
  localparam logic [7:0]  PHANTOM_KEY  = 8'h01;

  localparam logic [0:0] REG_DELAY  = 1'b0;
  localparam logic [0:0] REG_PERIOD = 1'b1;

  localparam logic [7:0] MOD_CODES [8] = '{
    8'h1D, 8'h2A, 8'h38, 8'h00, 8'h9D, 8'h36, 8'hB8, 8'h00
  };

  localparam logic [7:0] SET1_OF_USAGE [USAGE_TABLE_SIZE] = '{
    8'h00, 8'h00, 8'h00, 8'h00,
    8'h1E, 8'h30, 8'h2E, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24, 8'h25, 8'h26,
    8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1F, 8'h14, 8'h16, 8'h2F, 8'h11, 8'h2D,
    8'h15, 8'h2C,
    8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B,
    8'h1C, 8'h01, 8'h0E, 8'h0F, 8'h39,
    8'h0C, 8'h0D, 8'h1A, 8'h1B, 8'h2B, 8'h2B, 8'h27, 8'h28, 8'h29, 8'h33, 8'h34, 8'h35,
    8'h3A,
    8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h57, 8'h58,
    8'h00, 8'h00, 8'h00,
    8'hD2, 8'hC7, 8'hC9, 8'hD3, 8'hCF, 8'hD1,
    8'hCD, 8'hCB, 8'hD0, 8'hC8,
    8'h45, 8'hB5, 8'h37, 8'h4A, 8'h4E, 8'h9C,
    8'h4F, 8'h50, 8'h51, 8'h4B, 8'h4C, 8'h4D, 8'h47, 8'h48, 8'h49, 8'h52, 8'h53,
    8'h56, 8'h00
  };

  typedef struct packed {
    logic                          is_tick;
    logic [7:0]                    mods;
    logic [REPORT_SLOTS-1:0][7:0]  keys;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } fq_head_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } oq_entry_t;

  typedef struct packed {
    logic      push;
    oq_entry_t entry;
  } oq_push_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MOD,
    BK_REL,
    BK_PRS,
    BK_TICK,
    BK_TREP,
    BK_FIN
  } back_state_t;

  // Set 1 code of a usage, with bit 7 marking an extended code; zero means none.
  function automatic logic [7:0] usage_code(input logic [7:0] usage);
    logic [7:0] code;
    code = 8'h00;
    if (32'(usage) < USAGE_TABLE_SIZE) begin
      code = SET1_OF_USAGE[usage[6:0]];
    end
    return code;
  endfunction

endpackage

`default_nettype wire

// File: design/hkb_front.sv
// Front end: accepts input items, drops ignored reports and queues the rest.
`default_nettype none

module hkb_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               operation,
  input  wire logic [3:0]         report_length,
  input  wire hkb_pkg::item_t     in_item,
  output hkb_pkg::fq_head_t       head,
  input  wire logic               take
);
  import hkb_pkg::*;

  item_t      q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       phantom;
  logic       keep;
  logic       wr_en;
  logic       rd_en;

  assign full    = (count == 2'd2);
  assign phantom = (in_item.keys[0] == PHANTOM_KEY) && (in_item.keys[1] == PHANTOM_KEY) &&
                   (in_item.keys[2] == PHANTOM_KEY);
  assign keep    = operation || ((report_length >= 4'd8) && !phantom);
  assign wr_en   = push && !full && keep;
  assign rd_en   = take && (count != 2'd0);

  assign head.valid = (count != 2'd0);
  assign head.item  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= !rd_ptr;
      end
      if (wr_en && !rd_en) begin
        count <= count + 2'd1;
      end else if (rd_en && !wr_en) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/hkb_back.sv
// Back end: walks modifiers, releases and presses or a tick, and produces scancode bytes.
`default_nettype none

module hkb_back #(
  parameter int KEY_SLOTS = 6
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hkb_pkg::fq_head_t head,
  output logic                   take,
  input  wire logic [15:0]       repeat_delay_ticks,
  input  wire logic [15:0]       repeat_period_ticks,
  output hkb_pkg::oq_push_t      oq,
  input  wire logic              oq_full
);
  import hkb_pkg::*;

  localparam int SLOT_W = $clog2(KEY_SLOTS);

  back_state_t                 state;
  back_state_t                 state_next;
  logic [IDX_W-1:0]            idx;
  logic [SLOT_W-1:0]           slot;
  logic                        last_slot;
  logic                        prefix_done;
  logic                        fire;
  logic                        hold_valid;
  logic [7:0]                  hold_byte;

  logic [7:0]                  mods;
  logic [KEY_SLOTS-1:0][7:0]   cur_keys;
  logic [7:0]                  prev_mods;
  logic [KEY_SLOTS-1:0][7:0]   prev_keys;
  logic [7:0]                  held_key;
  logic [15:0]                 tsp;
  logic [15:0]                 tsr;

  logic [15:0]                 tsp_inc;
  logic [15:0]                 tsr_inc;
  logic                        fire_now;
  logic [7:0]                  usage;
  logic                        step_hit;
  logic [7:0]                  code;
  logic                        down;
  logic                        emit_ok;
  logic                        need_prefix;
  logic                        emit;
  logic                        step_done;
  logic [7:0]                  emit_byte;
  logic                        fin_push;

  function automatic logic key_in(input logic [KEY_SLOTS-1:0][7:0] ks, input logic [7:0] u);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (ks[i] == u) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  assign slot      = idx[SLOT_W-1:0];
  assign last_slot = (slot == SLOT_W'(KEY_SLOTS - 1));
  assign tsp_inc   = (tsp == TICK_MAX) ? tsp : tsp + 16'd1;
  assign tsr_inc   = (tsr == TICK_MAX) ? tsr : tsr + 16'd1;
  assign fire_now  = (held_key != 8'h00) && (tsp_inc >= repeat_delay_ticks) &&
                     (tsr_inc >= repeat_period_ticks);

  always_comb begin
    usage    = 8'h00;
    step_hit = 1'b0;
    code     = 8'h00;
    down     = 1'b1;
    case (state)
      BK_MOD: begin
        step_hit = (prev_mods[idx] != mods[idx]);
        code     = step_hit ? MOD_CODES[idx] : 8'h00;
        down     = mods[idx];
      end
      BK_REL: begin
        usage    = prev_keys[slot];
        step_hit = (usage != 8'h00) && !key_in(cur_keys, usage);
        code     = step_hit ? usage_code(usage) : 8'h00;
        down     = 1'b0;
      end
      BK_PRS: begin
        usage    = cur_keys[slot];
        step_hit = (usage != 8'h00) && !key_in(prev_keys, usage);
        code     = step_hit ? usage_code(usage) : 8'h00;
      end
      BK_TREP: begin
        step_hit = fire;
        code     = fire ? usage_code(held_key) : 8'h00;
      end
      default: begin
      end
    endcase
    emit_ok     = !hold_valid || !oq_full;
    need_prefix = code[7] && !prefix_done;
    emit        = (code != 8'h00) && emit_ok;
    step_done   = (code == 8'h00) || (emit_ok && !need_prefix);
    emit_byte   = need_prefix ? EXT_PREFIX : {!down, code[6:0]};
    fin_push    = (state == BK_FIN) && hold_valid && !oq_full;
    oq.push       = (emit && hold_valid) || fin_push;
    oq.entry.data = hold_byte;
    oq.entry.last = fin_push;
    take          = (state == BK_IDLE) && head.valid;
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (head.valid) begin
          state_next = head.item.is_tick ? BK_TICK : BK_MOD;
        end
      end
      BK_MOD: begin
        if (step_done && (idx == IDX_W'(7))) begin
          state_next = BK_REL;
        end
      end
      BK_REL: begin
        if (step_done && last_slot) begin
          state_next = BK_PRS;
        end
      end
      BK_PRS: begin
        if (step_done && last_slot) begin
          state_next = BK_FIN;
        end
      end
      BK_TICK: begin
        state_next = BK_TREP;
      end
      BK_TREP: begin
        if (step_done) begin
          state_next = BK_FIN;
        end
      end
      BK_FIN: begin
        if (!hold_valid || !oq_full) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mods <= head.item.mods;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        cur_keys[i] <= head.item.keys[i];
      end
    end
    if (emit) begin
      hold_byte <= emit_byte;
    end
    if (state == BK_TICK) begin
      fire <= fire_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_IDLE;
      idx         <= '0;
      prefix_done <= 1'b0;
      hold_valid  <= 1'b0;
      prev_mods   <= 8'h00;
      prev_keys   <= '0;
      held_key    <= 8'h00;
      tsp         <= 16'd0;
      tsr         <= 16'd0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        idx <= '0;
      end else if (step_done && ((state == BK_MOD) || (state == BK_REL) ||
                                 (state == BK_PRS))) begin
        idx <= idx + IDX_W'(1);
      end
      if (step_done) begin
        prefix_done <= 1'b0;
      end else if (emit && need_prefix) begin
        prefix_done <= 1'b1;
      end
      if (emit) begin
        hold_valid <= 1'b1;
      end else if (fin_push) begin
        hold_valid <= 1'b0;
      end
      if (state == BK_TICK) begin
        tsp <= tsp_inc;
        tsr <= fire_now ? 16'd0 : tsr_inc;
      end
      if ((state == BK_TREP) && fire && step_done) begin
        tsr <= 16'd0;
      end
      if ((state == BK_REL) && step_done && step_hit && (held_key == usage)) begin
        held_key <= 8'h00;
      end
      if ((state == BK_PRS) && step_done) begin
        if (step_hit) begin
          held_key <= usage;
          tsp      <= 16'd0;
          tsr      <= 16'd0;
        end
        if (last_slot) begin
          prev_mods <= mods;
          prev_keys <= cur_keys;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: design/hkb_outq.sv
// Result queue holding scancode bytes until the receiver takes them.
`default_nettype none

module hkb_outq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hkb_pkg::oq_push_t in_push,
  output logic                   full,
  output logic                   empty,
  input  wire logic              pop,
  output hkb_pkg::oq_entry_t     head
);
  import hkb_pkg::*;

  oq_entry_t             q [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr;
  logic [OUTQ_PTR_W-1:0] rd_ptr;
  logic [OUTQ_PTR_W:0]   count;
  logic                  wr_en;
  logic                  rd_en;

  assign full  = (count == (OUTQ_PTR_W + 1)'(OUTQ_DEPTH));
  assign empty = (count == '0);
  assign wr_en = in_push.push && !full;
  assign rd_en = pop && !empty;
  assign head  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q[wr_ptr] <= in_push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + OUTQ_PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + OUTQ_PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + (OUTQ_PTR_W + 1)'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - (OUTQ_PTR_W + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: design/hid_keyboard_report_to_set1.sv
// Top level: converts boot keyboard reports and ticks into set 1 scancode bytes.
//
// Items are pushed with push while full is low; operation selects a keyboard
// report or one time tick. Reports shorter than eight bytes and phantom reports
// are taken and discarded at once. Result bytes come out in order through a
// queue: the oldest byte sits on scancode_byte while empty is low and leaves on
// pop, with last_of_run marking the final byte of each item.
// A report enters the back end from the front queue, then passes eight modifier steps
// and KEY_SLOTS release and KEY_SLOTS press steps, with an extra step for the
// prefix byte of each extended code, and one closing step. A tick passes
// through a tick step, a repeat step and the closing step. A two-entry queue
// in front lets new items arrive while one is worked on.
// When the receiver stalls, the four-entry result queue fills and the
// sequencer waits on the step it has reached; nothing is lost.
// Reset empties both queues, clears the previous report, the held key and the
// tick counters, and sets the repeat delay to 500 and the period to 33 ticks.
// The registers sit at byte addresses 0 (delay) and 4 (period).
`default_nettype none

module hid_keyboard_report_to_set1 #(
  parameter int KEY_SLOTS = 6
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        operation,
  input  wire logic [3:0]  report_length,
  input  wire logic [7:0]  modifier_bits,
  input  wire logic [7:0]  key_slot_0,
  input  wire logic [7:0]  key_slot_1,
  input  wire logic [7:0]  key_slot_2,
  input  wire logic [7:0]  key_slot_3,
  input  wire logic [7:0]  key_slot_4,
  input  wire logic [7:0]  key_slot_5,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       scancode_byte,
  output logic             last_of_run,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import hkb_pkg::*;

  item_t       in_item;
  fq_head_t    fq_head;
  logic        take;
  oq_push_t    oq_push;
  logic        oq_full;
  oq_entry_t   oq_head;
  logic [15:0] repeat_delay_ticks;
  logic [15:0] repeat_period_ticks;
  logic        cfg_write;

  assign in_item.is_tick = operation;
  assign in_item.mods    = modifier_bits;
  assign in_item.keys    = {key_slot_5, key_slot_4, key_slot_3,
                            key_slot_2, key_slot_1, key_slot_0};

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_PERIOD) ? {16'h0000, repeat_period_ticks}
                                              : {16'h0000, repeat_delay_ticks};

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_delay_ticks  <= DELAY_RESET;
      repeat_period_ticks <= PERIOD_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_DELAY) begin
        repeat_delay_ticks <= pwdata[15:0];
      end else begin
        repeat_period_ticks <= pwdata[15:0];
      end
    end
  end

  hkb_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .operation     (operation),
    .report_length (report_length),
    .in_item       (in_item),
    .head          (fq_head),
    .take          (take)
  );

  hkb_back #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_back (
    .clk                 (clk),
    .rst                 (rst),
    .head                (fq_head),
    .take                (take),
    .repeat_delay_ticks  (repeat_delay_ticks),
    .repeat_period_ticks (repeat_period_ticks),
    .oq                  (oq_push),
    .oq_full             (oq_full)
  );

  hkb_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .in_push (oq_push),
    .full    (oq_full),
    .empty   (empty),
    .pop     (pop),
    .head    (oq_head)
  );

  assign scancode_byte = oq_head.data;
  assign last_of_run   = oq_head.last;

endmodule

`default_nettype wire

// File: design/hkb_checker.sv
// Port-level checker for the keyboard scancode block, bound to its top level.
`default_nettype none
`include "hid_keyboard_report_to_set1_defines.svh"

module hkb_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [7:0]  scancode_byte,
  input wire logic        last_of_run,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [2:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata
);

  `HKB_ASSERT_RST(a_reset_state, empty && !full, "queues not empty after reset")

  `HKB_ASSERT_NEXT(a_head_held, !empty && !pop,
    !empty && $stable(scancode_byte) && $stable(last_of_run), "waiting result changed")

  `HKB_ASSERT(a_reg_readback, (psel && penable && pwrite) ##1 (paddr[2] == $past(paddr[2])),
    prdata[15:0] == $past(pwdata[15:0]), "register does not read back the written value")

  `HKB_ASSERT(a_read_upper, 1'b1, prdata[31:16] == 16'h0000, "unused read bits not zero")

endmodule

bind hid_keyboard_report_to_set1 hkb_checker u_hkb_checker (
  .clk           (clk),
  .rst           (rst),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .scancode_byte (scancode_byte),
  .last_of_run   (last_of_run),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);

`default_nettype wire
